// File: rtl/two_level_key_occurrence_counter_macros.svh
// Assertion macros shared by tlkoc_front and tlkoc_back.
`ifndef TWO_LEVEL_KEY_OCCURRENCE_COUNTER_MACROS_SVH
`define TWO_LEVEL_KEY_OCCURRENCE_COUNTER_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: rtl/tlkoc_pkg.sv
`default_nettype none
package tlkoc_pkg;
  localparam int GROUP_SLOTS_DEF = 10;
  localparam int KEY_SLOTS_DEF = 1024;
  localparam int MAX_GROUP_ID = 9;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_INVALID = 3'd1,
    ST_GROUP_FULL = 3'd2,
    ST_KEY_FULL = 3'd3,
    ST_HALTED = 3'd4
  } status_t;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic        rd;
    logic        halt;
    logic        invalid;
    logic [3:0]  gid;
    logic [30:0] kid;
    logic [3:0]  gslot;
    logic [9:0]  kslot;
  } cmd_t;
endpackage
`default_nettype wire

// File: rtl/tlkoc_front.sv
`default_nettype none
module tlkoc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic signed [31:0] group_id,
  input  wire logic signed [31:0] key_id,
  input  wire logic [3:0]         group_slot,
  input  wire logic [9:0]         key_slot,
  output logic                    q_valid,
  input  wire logic               q_pop,
  output tlkoc_pkg::cmd_t         q_cmd
);
  import tlkoc_pkg::*;
  `include "two_level_key_occurrence_counter_macros.svh"

  // Two-entry queue; the front sees a halt flag that it sets itself on an invalid
  // count item so that later items are classified as halted.
  cmd_t q_mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic halt_seen;
  logic push;
  cmd_t c;
  logic gfull;

  assign in_stall = (cnt == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = q_mem[rp];

  always_comb begin
    c.rd = (opcode == OP_READ);
    c.halt = halt_seen;
    c.invalid = (group_id < 0) || (group_id > MAX_GROUP_ID) || key_id[31];
    c.gid = group_id[3:0];
    c.kid = key_id[30:0];
    c.gslot = group_slot;
    c.kslot = key_slot;
  end
  assign gfull = 1'b0;

  always_ff @(posedge clk) begin
    if (push) q_mem[wp] <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
      halt_seen <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
      if (push && !c.rd && c.invalid && !gfull) halt_seen <= 1'b1;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push, cnt != 2'd2)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, q_pop, cnt != 2'd0)
  `ASSERT_NEXT(a_halt_sticks, clk, rst, halt_seen, halt_seen)
endmodule
`default_nettype wire

// File: rtl/tlkoc_back.sv
`default_nettype none
module tlkoc_back #(
  parameter int GROUP_SLOTS = tlkoc_pkg::GROUP_SLOTS_DEF,
  parameter int KEY_SLOTS = tlkoc_pkg::KEY_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  tlkoc_pkg::cmd_t  q_cmd,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [3:0]       found_group,
  output logic [30:0]      found_key,
  output logic [31:0]      occurrences,
  output logic             entry_valid,
  output logic [3:0]       groups_in_use,
  output logic [10:0]      keys_in_group
);
  import tlkoc_pkg::*;
  `include "two_level_key_occurrence_counter_macros.svh"

  localparam int GW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int KW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int NW = $clog2(KEY_SLOTS + 1);
  localparam int DEPTH = GROUP_SLOTS * KEY_SLOTS;
  localparam int AW = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_KREQ  = 6'b000010,
    S_KCMP  = 6'b000100,
    S_INC   = 6'b001000,
    S_WRITE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic halted;
  logic [3:0] gcount;
  logic [3:0] gids [GROUP_SLOTS];
  logic [NW-1:0] kpg [GROUP_SLOTS];
  logic [30:0] key_mem [DEPTH];
  logic [31:0] cnt_mem [DEPTH];
  logic [30:0] key_rd;
  logic [31:0] cnt_rd;
  logic [AW-1:0] rd_addr, wr_addr;
  logic key_we, cnt_we;
  logic [30:0] key_wd;
  logic [31:0] cnt_wd;

  cmd_t cmd;
  logic [GW-1:0] gsel;
  logic [KW:0] kidx;
  logic [NW-1:0] nkeys;
  logic [31:0] occ;

  // Group lookup is over GROUP_SLOTS narrow registers (ten by default) and is combinational.
  logic ghit;
  logic [GW-1:0] ghit_idx;
  always_comb begin
    ghit = 1'b0;
    ghit_idx = '0;
    for (int i = GROUP_SLOTS - 1; i >= 0; i--) begin
      if (i < int'(gcount) && gids[i] == q_cmd.gid) begin
        ghit = 1'b1;
        ghit_idx = GW'(i);
      end
    end
  end

  logic [GW-1:0] rsel;
  logic rgvalid;
  assign rgvalid = (q_cmd.gslot < gcount) && (int'(q_cmd.gslot) < GROUP_SLOTS);
  assign rsel = GW'(q_cmd.gslot);

  always_ff @(posedge clk) begin
    key_rd <= key_mem[rd_addr];
    cnt_rd <= cnt_mem[rd_addr];
    if (key_we) key_mem[wr_addr] <= key_wd;
    if (cnt_we) cnt_mem[wr_addr] <= cnt_wd;
  end

  function automatic logic [AW-1:0] addr(input logic [GW-1:0] g, input logic [KW:0] k);
    logic [AW+KW:0] a;
    a = (AW+KW+1)'(g) * (AW+KW+1)'(KEY_SLOTS) + (AW+KW+1)'(k);
    return a[AW-1:0];
  endfunction

  assign q_pop = (state == S_IDLE) && q_valid && !out_valid;

  always_comb begin
    rd_addr = addr(gsel, kidx);
    if (state == S_IDLE) rd_addr = addr(rsel, {1'b0, q_cmd.kslot[KW-1:0]});
    wr_addr = addr(gsel, kidx);
    key_we = (state == S_WRITE);
    cnt_we = (state == S_WRITE);
    key_wd = cmd.kid;
    cnt_wd = occ;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      halted <= 1'b0;
      gcount <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cmd <= q_cmd;
            found_group <= '0;
            found_key <= '0;
            occurrences <= '0;
            entry_valid <= 1'b0;
            keys_in_group <= '0;
            groups_in_use <= gcount;
            status <= ST_OK;
            if (halted || q_cmd.halt) begin
              status <= ST_HALTED;
              groups_in_use <= '0;
              out_valid <= 1'b1;
            end else if (q_cmd.rd) begin
              gsel <= rsel;
              if (rgvalid) begin
                found_group <= gids[rsel];
                keys_in_group <= 11'(kpg[rsel]);
                if (int'(q_cmd.kslot) < int'(kpg[rsel])) begin
                  entry_valid <= 1'b1;
                  state <= S_OUT;
                end else begin
                  out_valid <= 1'b1;
                end
              end else begin
                out_valid <= 1'b1;
              end
            end else if (q_cmd.invalid) begin
              status <= ST_INVALID;
              halted <= 1'b1;
              out_valid <= 1'b1;
            end else if (ghit) begin
              gsel <= ghit_idx;
              nkeys <= kpg[ghit_idx];
              kidx <= '0;
              state <= S_KREQ;
            end else if (int'(gcount) >= GROUP_SLOTS) begin
              status <= ST_GROUP_FULL;
              halted <= 1'b1;
              out_valid <= 1'b1;
            end else begin
              gsel <= gcount[GW-1:0];
              gids[gcount[GW-1:0]] <= q_cmd.gid;
              kpg[gcount[GW-1:0]] <= '0;
              gcount <= gcount + 4'd1;
              groups_in_use <= gcount + 4'd1;
              nkeys <= '0;
              kidx <= '0;
              state <= S_KREQ;
            end
          end
        end
        S_KREQ: begin
          // Memory read of slot kidx is under way; empty tail means a new key.
          if ((NW)'(kidx) >= nkeys) begin
            if (int'(nkeys) >= KEY_SLOTS) begin
              status <= ST_KEY_FULL;
              halted <= 1'b1;
              keys_in_group <= 11'(nkeys);
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              occ <= 32'd1;
              kpg[gsel] <= nkeys + 1'b1;
              nkeys <= nkeys + 1'b1;
              state <= S_WRITE;
            end
          end else begin
            state <= S_KCMP;
          end
        end
        S_KCMP: begin
          if (key_rd == cmd.kid) begin
            state <= S_INC;
          end else begin
            kidx <= kidx + 1'b1;
            state <= S_KREQ;
          end
        end
        S_INC: begin
          occ <= (cnt_rd == 32'hFFFF_FFFF) ? cnt_rd : cnt_rd + 32'd1;
          state <= S_WRITE;
        end
        S_WRITE: begin
          status <= ST_OK;
          found_group <= cmd.gid;
          found_key <= cmd.kid;
          occurrences <= occ;
          entry_valid <= 1'b1;
          keys_in_group <= 11'(nkeys);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_OUT: begin
          found_key <= key_rd;
          occurrences <= cnt_rd;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_pop_idle, clk, rst, q_pop, state == S_IDLE)
  `ASSERT_IMPLIES(a_gcount_range, clk, rst, 1'b1, int'(gcount) <= GROUP_SLOTS)
  `ASSERT_NEXT(a_halted_sticks, clk, rst, halted, halted)
endmodule
`default_nettype wire

// File: rtl/two_level_key_occurrence_counter.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_stall   | opcode group_id key_id group_slot key_slot
// out     | output    | out_valid/out_stall | status found_group found_key occurrences
//         |           |                     | entry_valid groups_in_use keys_in_group
// A count item scans the key slots of its group in turn; each slot costs a registered
// memory read (S_KREQ) and then a compare (S_KCMP). A read item needs no scan.
// A two-beat queue sits in front of the engine, which takes an item only in S_IDLE with no output beat pending.
// Reset clears control state only; memories need no clearing pass.
// An output beat is held until out_stall is low.
`default_nettype none
module two_level_key_occurrence_counter #(
  parameter int GROUP_SLOTS = tlkoc_pkg::GROUP_SLOTS_DEF,
  parameter int KEY_SLOTS = tlkoc_pkg::KEY_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic signed [31:0] group_id,
  input  wire logic signed [31:0] key_id,
  input  wire logic [3:0]         group_slot,
  input  wire logic [9:0]         key_slot,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              status,
  output logic [3:0]              found_group,
  output logic [30:0]             found_key,
  output logic [31:0]             occurrences,
  output logic                    entry_valid,
  output logic [3:0]              groups_in_use,
  output logic [10:0]             keys_in_group
);
  import tlkoc_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  tlkoc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .opcode, .group_id, .key_id,
    .group_slot, .key_slot, .q_valid, .q_pop, .q_cmd
  );

  tlkoc_back #(.GROUP_SLOTS(GROUP_SLOTS), .KEY_SLOTS(KEY_SLOTS)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_cmd, .out_valid, .out_stall, .status,
    .found_group, .found_key, .occurrences, .entry_valid, .groups_in_use,
    .keys_in_group
  );
endmodule
`default_nettype wire
